@@ rtl/calsec_pkg.sv @@
// shared types, limits and calendar functions of the calendar seconds counter
package calsec_pkg;

   localparam int unsigned SEC_W   = 6;
   localparam int unsigned MIN_W   = 6;
   localparam int unsigned HOUR_W  = 5;
   localparam int unsigned DAY_W   = 5;
   localparam int unsigned MONTH_W = 4;
   localparam int unsigned YEAR_W  = 8;

   localparam logic [SEC_W-1:0]   SEC_MAX   = SEC_W'(59);
   localparam logic [MIN_W-1:0]   MIN_MAX   = MIN_W'(59);
   localparam logic [HOUR_W-1:0]  HOUR_MAX  = HOUR_W'(23);
   localparam logic [MONTH_W:0]   MONTH_END = (MONTH_W + 1)'(13);

   localparam logic [DAY_W-1:0]   DAY_FIRST   = DAY_W'(1);
   localparam logic [MONTH_W-1:0] MONTH_JAN   = MONTH_W'(1);
   localparam logic [MONTH_W-1:0] MONTH_FEB   = MONTH_W'(2);
   localparam logic [MONTH_W-1:0] MONTH_APR   = MONTH_W'(4);
   localparam logic [MONTH_W-1:0] MONTH_JUN   = MONTH_W'(6);
   localparam logic [MONTH_W-1:0] MONTH_SEP   = MONTH_W'(9);
   localparam logic [MONTH_W-1:0] MONTH_NOV   = MONTH_W'(11);

   // century years inside the 2000..2255 window that are not leap years
   localparam logic [YEAR_W-1:0]  YEAR_2100 = YEAR_W'(100);
   localparam logic [YEAR_W-1:0]  YEAR_2200 = YEAR_W'(200);

   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_LOAD = 1'b1;

   typedef struct packed {
      logic               command;
      logic [SEC_W-1:0]   load_seconds;
      logic [MIN_W-1:0]   load_minutes;
      logic [HOUR_W-1:0]  load_hours;
      logic [DAY_W-1:0]   load_day;
      logic [MONTH_W-1:0] load_month;
      logic [YEAR_W-1:0]  load_year;
   } req_item_type;

   typedef struct packed {
      logic [SEC_W-1:0]   seconds;
      logic [MIN_W-1:0]   minutes;
      logic [HOUR_W-1:0]  hours;
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
   } time_type;

   // 2000 is a multiple of 400, so the offset alone decides
   function automatic logic is_leap(input logic [YEAR_W-1:0] offset);
      is_leap = (offset[1:0] == 2'b00) && (offset != YEAR_2100) && (offset != YEAR_2200);
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                  input logic [YEAR_W-1:0]  offset);
      if (month == MONTH_FEB) begin
         month_len = is_leap(offset) ? DAY_W'(29) : DAY_W'(28);
      end else if ((month == MONTH_APR) || (month == MONTH_JUN) ||
                   (month == MONTH_SEP) || (month == MONTH_NOV)) begin
         month_len = DAY_W'(30);
      end else begin
         month_len = DAY_W'(31);
      end
   endfunction

endpackage

@@ rtl/calendar_seconds_counter.sv @@
// real-time clock calendar counter with tick and load commands
//
// Each accepted item either advances the clock by one second (command tick) or
// loads the full time from the load fields (command load), and produces exactly
// one result item carrying the time after that step. Data path: an item is
// captured in an input register, the cascade of seconds, minutes, hours, day,
// month and year is evaluated in one short combinational pass, and the new time
// lands in the time registers, which double as the result register. rsp_valid
// rises with the new time in the time registers; one item per clock is
// sustained as long as rsp_stall stays low. While a result is held by rsp_stall
// the block still takes one more item into its input register. Reset time is
// 00:00:00 on January 1, year offset 0 (2000). Loaded values are stored
// unchecked; a day past the month's end rolls over at the next day change, and
// a month outside 1..12 counts as 31 days long. Leap years follow the Gregorian
// rule over 2000..2255 (2100 and 2200 are not leap years); the year offset
// wraps at 255.
module calendar_seconds_counter (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_command,
   input  logic [calsec_pkg::SEC_W-1:0]    req_load_seconds,
   input  logic [calsec_pkg::MIN_W-1:0]    req_load_minutes,
   input  logic [calsec_pkg::HOUR_W-1:0]   req_load_hours,
   input  logic [calsec_pkg::DAY_W-1:0]    req_load_day,
   input  logic [calsec_pkg::MONTH_W-1:0]  req_load_month,
   input  logic [calsec_pkg::YEAR_W-1:0]   req_load_year,

   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [calsec_pkg::SEC_W-1:0]    rsp_seconds,
   output logic [calsec_pkg::MIN_W-1:0]    rsp_minutes,
   output logic [calsec_pkg::HOUR_W-1:0]   rsp_hours,
   output logic [calsec_pkg::DAY_W-1:0]    rsp_day_of_month,
   output logic [calsec_pkg::MONTH_W-1:0]  rsp_month_number,
   output logic [calsec_pkg::YEAR_W-1:0]   rsp_year_offset
);

   // input register
   logic                     in_valid_ff;
   calsec_pkg::req_item_type in_item_ff;

   // current time, also the result register
   calsec_pkg::time_type     time_ff;
   calsec_pkg::time_type     time_in;
   logic                     rsp_valid_ff;

   // handshake control
   logic                     advance;
   logic                     take_req;

   // cascade terms
   logic [calsec_pkg::SEC_W:0]   sec_sum;
   logic [calsec_pkg::MIN_W:0]   min_sum;
   logic [calsec_pkg::HOUR_W:0]  hour_sum;
   logic [calsec_pkg::DAY_W:0]   day_sum;
   logic [calsec_pkg::MONTH_W:0] month_sum;
   logic [calsec_pkg::DAY_W-1:0] cur_len;
   logic                         sec_carry;
   logic                         min_carry;
   logic                         hour_carry;
   logic                         day_carry;
   logic                         month_carry;

   // the buffered item moves on when the result slot is empty or being taken
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign take_req  = req_valid && !req_stall;

   // one-second cascade chained by carries; the day stage also uses the month length
   always_comb begin
      sec_sum   = {1'b0, time_ff.seconds} + (calsec_pkg::SEC_W + 1)'(1);
      min_sum   = {1'b0, time_ff.minutes} + (calsec_pkg::MIN_W + 1)'(1);
      hour_sum  = {1'b0, time_ff.hours} + (calsec_pkg::HOUR_W + 1)'(1);
      day_sum   = {1'b0, time_ff.day} + (calsec_pkg::DAY_W + 1)'(1);
      month_sum = {1'b0, time_ff.month} + (calsec_pkg::MONTH_W + 1)'(1);
      cur_len   = calsec_pkg::month_len(time_ff.month, time_ff.year);

      sec_carry   = sec_sum > {1'b0, calsec_pkg::SEC_MAX};
      min_carry   = sec_carry && (min_sum > {1'b0, calsec_pkg::MIN_MAX});
      hour_carry  = min_carry && (hour_sum > {1'b0, calsec_pkg::HOUR_MAX});
      day_carry   = hour_carry && (day_sum > {1'b0, cur_len});
      month_carry = day_carry && (month_sum >= calsec_pkg::MONTH_END);

      time_in = time_ff;
      if (in_item_ff.command == calsec_pkg::CMD_LOAD) begin
         time_in.seconds = in_item_ff.load_seconds;
         time_in.minutes = in_item_ff.load_minutes;
         time_in.hours   = in_item_ff.load_hours;
         time_in.day     = in_item_ff.load_day;
         time_in.month   = in_item_ff.load_month;
         time_in.year    = in_item_ff.load_year;
      end else begin
         time_in.seconds = sec_carry ? '0 : sec_sum[calsec_pkg::SEC_W-1:0];
         if (sec_carry) begin
            time_in.minutes = min_carry ? '0 : min_sum[calsec_pkg::MIN_W-1:0];
         end
         if (min_carry) begin
            time_in.hours = hour_carry ? '0 : hour_sum[calsec_pkg::HOUR_W-1:0];
         end
         if (hour_carry) begin
            time_in.day = day_carry ? calsec_pkg::DAY_FIRST : day_sum[calsec_pkg::DAY_W-1:0];
         end
         if (day_carry) begin
            // month 13 and up wrap to january of the next year
            time_in.month = month_carry ? calsec_pkg::MONTH_JAN
                                        : month_sum[calsec_pkg::MONTH_W-1:0];
         end
         if (month_carry) begin
            time_in.year = time_ff.year + calsec_pkg::YEAR_W'(1);
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         time_ff      <= '{seconds: '0, minutes: '0, hours: '0,
                           day: calsec_pkg::DAY_FIRST, month: calsec_pkg::MONTH_JAN,
                           year: '0};
      end else begin
         if (take_req) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end

         if (advance) begin
            rsp_valid_ff <= 1'b1;
            time_ff      <= time_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // input payload, no reset needed
   always_ff @(posedge clock) begin
      if (take_req) begin
         in_item_ff <= '{command: req_command, load_seconds: req_load_seconds,
                         load_minutes: req_load_minutes, load_hours: req_load_hours,
                         load_day: req_load_day, load_month: req_load_month,
                         load_year: req_load_year};
      end
   end

   // result item is the time register itself
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_seconds      = time_ff.seconds;
   assign rsp_minutes      = time_ff.minutes;
   assign rsp_hours        = time_ff.hours;
   assign rsp_day_of_month = time_ff.day;
   assign rsp_month_number = time_ff.month;
   assign rsp_year_offset  = time_ff.year;

endmodule

@@ tb/calendar_seconds_counter_checker.sv @@
// channel monitor, calendar predictor and result comparison for the calendar seconds counter
module calendar_seconds_counter_checker (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic                            req_command,
   input  logic [calsec_pkg::SEC_W-1:0]    req_load_seconds,
   input  logic [calsec_pkg::MIN_W-1:0]    req_load_minutes,
   input  logic [calsec_pkg::HOUR_W-1:0]   req_load_hours,
   input  logic [calsec_pkg::DAY_W-1:0]    req_load_day,
   input  logic [calsec_pkg::MONTH_W-1:0]  req_load_month,
   input  logic [calsec_pkg::YEAR_W-1:0]   req_load_year,

   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [calsec_pkg::SEC_W-1:0]    rsp_seconds,
   input  logic [calsec_pkg::MIN_W-1:0]    rsp_minutes,
   input  logic [calsec_pkg::HOUR_W-1:0]   rsp_hours,
   input  logic [calsec_pkg::DAY_W-1:0]    rsp_day_of_month,
   input  logic [calsec_pkg::MONTH_W-1:0]  rsp_month_number,
   input  logic [calsec_pkg::YEAR_W-1:0]   rsp_year_offset,

   output int                              err_count,
   output int                              pend_count,
   output int                              load_count,
   output int                              tick_count,
   output int                              month_changes,
   output int                              year_wraps,
   output int                              leap_days
);
   timeunit 1ns;
   timeprecision 1ps;

   import calsec_pkg::*;

   time_type kept_time;
   time_type expected_times[$];

   function automatic bit leap_year(input logic [YEAR_W-1:0] offset);
      int full;
      full = 2000 + int'(offset);
      return ((full % 4 == 0) && (full % 100 != 0)) || (full % 400 == 0);
   endfunction

   function automatic int days_in_month(input logic [MONTH_W-1:0] month,
                                        input logic [YEAR_W-1:0]  offset);
      case (month)
         MONTH_FEB:                                return leap_year(offset) ? 29 : 28;
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: return 30;
         default:                                  return 31;
      endcase
   endfunction

   // widened compares so that loaded values past the limits still carry
   function automatic time_type advance_one_second(input time_type t);
      time_type n;
      n = t;
      if (int'(t.seconds) + 1 <= int'(SEC_MAX)) begin
         n.seconds = t.seconds + 1'b1;
      end else begin
         n.seconds = '0;
         if (int'(t.minutes) + 1 <= int'(MIN_MAX)) begin
            n.minutes = t.minutes + 1'b1;
         end else begin
            n.minutes = '0;
            if (int'(t.hours) + 1 <= int'(HOUR_MAX)) begin
               n.hours = t.hours + 1'b1;
            end else begin
               n.hours = '0;
               if (int'(t.day) + 1 > days_in_month(t.month, t.year)) begin
                  n.day = DAY_FIRST;
                  if (int'(t.month) + 1 >= int'(MONTH_END)) begin
                     n.month = MONTH_JAN;
                     n.year  = t.year + 1'b1;
                  end else begin
                     n.month = t.month + 1'b1;
                  end
               end else begin
                  n.day = t.day + 1'b1;
               end
            end
         end
      end
      return n;
   endfunction

   task automatic report_mismatch(input string msg);
      err_count++;
      $display("%0t mismatch: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   always @(posedge clock) begin : watch
      time_type want_t;
      time_type prev_t;
      if (reset) begin
         kept_time     = '{'0, '0, '0, DAY_FIRST, MONTH_JAN, '0};
         expected_times.delete();
         err_count     = 0;
         load_count    = 0;
         tick_count    = 0;
         month_changes = 0;
         year_wraps    = 0;
         leap_days     = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_times.size() == 0) begin
               report_mismatch("result item with no expected time");
            end else begin
               want_t = expected_times.pop_front();
               check_field("seconds", rsp_seconds, want_t.seconds);
               check_field("minutes", rsp_minutes, want_t.minutes);
               check_field("hours", rsp_hours, want_t.hours);
               check_field("day_of_month", rsp_day_of_month, want_t.day);
               check_field("month_number", rsp_month_number, want_t.month);
               check_field("year_offset", rsp_year_offset, want_t.year);
            end
         end
         if (req_valid && !req_stall) begin
            if (req_command == CMD_LOAD) begin
               kept_time = '{req_load_seconds, req_load_minutes, req_load_hours,
                             req_load_day, req_load_month, req_load_year};
               load_count++;
            end else begin
               prev_t    = kept_time;
               kept_time = advance_one_second(kept_time);
               tick_count++;
               if (kept_time.month != prev_t.month) month_changes++;
               if (kept_time.year < prev_t.year) year_wraps++;
               if (kept_time.month == MONTH_FEB && kept_time.day == DAY_W'(29) &&
                   kept_time.day != prev_t.day) leap_days++;
            end
            expected_times.push_back(kept_time);
         end
      end
      pend_count <= expected_times.size();
   end

endmodule

@@ tb/calendar_seconds_counter_tb.sv @@
// stimulus, handshake pacing and verdict for the calendar seconds counter
module calendar_seconds_counter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import calsec_pkg::*;

   localparam int RESET_CYCLES    = 7;
   localparam int HOLD_OFF_CYCLES = 80;    // long receiver hold-off, fills the block
   localparam int DRAIN_CYCLES    = 10;    // rsp_valid follows the accept through the input register, slack
   localparam int WATCHDOG_LIMIT  = 1000;  // cycles with no handshake at all
   localparam int IDLE_PERCENT    = 17;

   logic                clock = 1'b0;
   logic                reset = 1'b1;

   logic                req_valid        = 1'b0;
   logic                req_stall;
   logic                req_command      = CMD_TICK;
   logic [SEC_W-1:0]    req_load_seconds = '0;
   logic [MIN_W-1:0]    req_load_minutes = '0;
   logic [HOUR_W-1:0]   req_load_hours   = '0;
   logic [DAY_W-1:0]    req_load_day     = DAY_FIRST;
   logic [MONTH_W-1:0]  req_load_month   = MONTH_JAN;
   logic [YEAR_W-1:0]   req_load_year    = '0;

   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [SEC_W-1:0]    rsp_seconds;
   logic [MIN_W-1:0]    rsp_minutes;
   logic [HOUR_W-1:0]   rsp_hours;
   logic [DAY_W-1:0]    rsp_day_of_month;
   logic [MONTH_W-1:0]  rsp_month_number;
   logic [YEAR_W-1:0]   rsp_year_offset;

   // pacing controls, written with nonblocking assignments only
   logic                no_idle      = 1'b0;
   logic                hold_off_req = 1'b0;

   int                  items_sent = 0;
   int                  err_count;
   int                  pend_count;
   int                  load_count;
   int                  tick_count;
   int                  month_changes;
   int                  year_wraps;
   int                  leap_days;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   calendar_seconds_counter i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_load_seconds (req_load_seconds),
      .req_load_minutes (req_load_minutes),
      .req_load_hours   (req_load_hours),
      .req_load_day     (req_load_day),
      .req_load_month   (req_load_month),
      .req_load_year    (req_load_year),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_seconds      (rsp_seconds),
      .rsp_minutes      (rsp_minutes),
      .rsp_hours        (rsp_hours),
      .rsp_day_of_month (rsp_day_of_month),
      .rsp_month_number (rsp_month_number),
      .rsp_year_offset  (rsp_year_offset)
   );

   calendar_seconds_counter_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_load_seconds (req_load_seconds),
      .req_load_minutes (req_load_minutes),
      .req_load_hours   (req_load_hours),
      .req_load_day     (req_load_day),
      .req_load_month   (req_load_month),
      .req_load_year    (req_load_year),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_seconds      (rsp_seconds),
      .rsp_minutes      (rsp_minutes),
      .rsp_hours        (rsp_hours),
      .rsp_day_of_month (rsp_day_of_month),
      .rsp_month_number (rsp_month_number),
      .rsp_year_offset  (rsp_year_offset),
      .err_count        (err_count),
      .pend_count       (pend_count),
      .load_count       (load_count),
      .tick_count       (tick_count),
      .month_changes    (month_changes),
      .year_wraps       (year_wraps),
      .leap_days        (leap_days)
   );

   // load item with every field at full width, out of range values included
   function automatic req_item_type raw_load();
      req_item_type it;
      it.command      = CMD_LOAD;
      it.load_seconds = SEC_W'($urandom);
      it.load_minutes = MIN_W'($urandom);
      it.load_hours   = HOUR_W'($urandom);
      it.load_day     = DAY_W'($urandom);
      it.load_month   = MONTH_W'($urandom);
      it.load_year    = YEAR_W'($urandom);
      return it;
   endfunction

   // tick with junk in the load fields, which the block must ignore
   function automatic req_item_type tick_item();
      req_item_type it;
      it         = raw_load();
      it.command = CMD_TICK;
      return it;
   endfunction

   function automatic req_item_type load_item(input int s, input int m, input int h,
                                              input int d, input int mo, input int y);
      req_item_type it;
      it.command      = CMD_LOAD;
      it.load_seconds = SEC_W'(s);
      it.load_minutes = MIN_W'(m);
      it.load_hours   = HOUR_W'(h);
      it.load_day     = DAY_W'(d);
      it.load_month   = MONTH_W'(mo);
      it.load_year    = YEAR_W'(y);
      return it;
   endfunction

   // offer one item, with a random gap first unless idling is off, and hold it until taken
   task automatic send_item(input req_item_type it);
      int gap;
      gap = 0;
      if (!no_idle) begin
         while ($urandom_range(99) < IDLE_PERCENT) gap++;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_command      <= it.command;
      req_load_seconds <= it.load_seconds;
      req_load_minutes <= it.load_minutes;
      req_load_hours   <= it.load_hours;
      req_load_day     <= it.load_day;
      req_load_month   <= it.load_month;
      req_load_year    <= it.load_year;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_ticks(input int count);
      repeat (count) send_item(tick_item());
   endtask

   task automatic load_then_tick(input int s, input int m, input int h,
                                 input int d, input int mo, input int y);
      send_item(load_item(s, m, h, d, mo, y));
      send_item(tick_item());
   endtask

   // sender stays quiet until every expected result item is back
   task automatic wait_all_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pend_count != 0);
   endtask

   // mostly loads just before a rollover followed by a few ticks, plus raw loads
   // and plain tick runs
   task automatic run_random(input int count);
      int           stop_at;
      int           pick;
      req_item_type it;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            it              = raw_load();
            it.load_seconds = SEC_W'($urandom_range(55, 59));
            it.load_minutes = ($urandom_range(9) < 8) ? MIN_MAX : MIN_W'($urandom_range(59));
            it.load_hours   = ($urandom_range(9) < 8) ? HOUR_MAX : HOUR_W'($urandom_range(23));
            // day near or past the end of the month, sometimes anything
            it.load_day     = ($urandom_range(3) == 0) ? DAY_W'($urandom)
                                                       : DAY_W'($urandom_range(27, 31));
            it.load_month   = ($urandom_range(9) == 0) ? MONTH_W'($urandom)
                                                       : MONTH_W'($urandom_range(1, 12));
            // century years and the wrap point get extra weight
            case ($urandom_range(6))
               0:       it.load_year = '0;
               1:       it.load_year = YEAR_2100;
               2:       it.load_year = YEAR_2200;
               3:       it.load_year = '1;
               4:       it.load_year = YEAR_W'(4 * $urandom_range(63));
               default: it.load_year = YEAR_W'($urandom);
            endcase
            send_item(it);
            send_ticks($urandom_range(1, 10));
         end else if (pick < 85) begin
            send_item(raw_load());
            send_ticks($urandom_range(0, 3));
         end else begin
            send_ticks($urandom_range(1, 20));
         end
      end
   endtask

   // receiver: random stalls, a quiet stretch, and one long hold-off on request
   initial begin : receiver
      bit hold_done;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req && !hold_done) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= !no_idle && ($urandom_range(99) < IDLE_PERCENT);
         end
      end
   end

   // watchdog on cycles with no handshake on either channel
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d result items outstanding",
                     quiet_cycles, pend_count);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin : stimulus
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // first tick straight out of reset
      send_item(tick_item());
      // end of year 255 wraps to january 1 of offset 0
      load_then_tick(59, 59, 23, 31, 12, 255);
      // february in 2000 is a leap month, then march 1
      load_then_tick(59, 59, 23, 28, 2, 0);
      load_then_tick(59, 59, 23, 29, 2, 0);
      // 2100 and 2200 skip the leap day
      load_then_tick(59, 59, 23, 28, 2, int'(YEAR_2100));
      load_then_tick(59, 59, 23, 28, 2, int'(YEAR_2200));
      // plain non-leap year
      load_then_tick(59, 59, 23, 28, 2, 1);
      // 30-day month rolls, 31-day month does not yet
      load_then_tick(59, 59, 23, 30, 4, 7);
      load_then_tick(59, 59, 23, 30, 1, 7);
      // loaded day already past the end of february
      load_then_tick(59, 59, 23, 30, 2, 3);
      // month zero counts as 31 days
      load_then_tick(59, 59, 23, 31, 0, 9);
      // every field all ones, most of them past their limits
      load_then_tick(63, 63, 31, 31, 15, 255);
      // every field zero
      load_then_tick(0, 0, 0, 0, 0, 0);

      run_random(550);

      // drain completely before the quiet stretch
      wait_all_results();

      // long stretch with no idling on either side
      no_idle <= 1'b1;
      run_random(250);

      // receiver holds off while the sender keeps offering back to back
      hold_off_req <= 1'b1;
      send_ticks(40);
      no_idle <= 1'b0;

      run_random(590);

      wait_all_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d loads and %0d ticks in %0d items", load_count, tick_count,
               items_sent);
      $display("saw %0d month changes, %0d year wraps and %0d leap days", month_changes,
               year_wraps, leap_days);
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
